// ----- rtl/rsd_pkg.sv -----
// Package for the radar sleep detector: request, event and class codes,
// payload and state structs shared by the rtl modules.
// No dependencies.
package rsd_pkg;

	// Score and run level at which sleep and steady breathing are declared
	localparam logic [7:0]  SLEEP_LEVEL = 8'd5;
	localparam logic [7:0]  RUN_LEVEL   = 8'd5;
	localparam logic [7:0]  SCORE_MAX   = 8'hFF;
	localparam logic [15:0] MOVE_MAX    = 16'hFFFF;

	// Configuration register indexes
	localparam logic [0:0] CFG_ENERGY_MIN = 1'b0;
	localparam logic [0:0] CFG_MAX_DIST   = 1'b1;

	// Reset values of the configuration registers
	localparam logic [7:0] ENERGY_MIN_RST = 8'd20;
	localparam logic [9:0] MAX_DIST_RST   = 10'd200;

	// Request type codes
	localparam logic [2:0] REQ_READING = 3'd0;
	localparam logic [2:0] REQ_START   = 3'd1;
	localparam logic [2:0] REQ_WAKE    = 3'd2;
	localparam logic [2:0] REQ_ENTER   = 3'd3;
	localparam logic [2:0] REQ_EXIT    = 3'd4;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_START = 2'd1,
		EV_END   = 2'd2,
		EV_MOVE  = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		CLS_ABSENT   = 2'd0,
		CLS_STABLE   = 2'd1,
		CLS_RESTLESS = 2'd2,
		CLS_OTHER    = 2'd3
	} class_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       ai_confident;
		logic [1:0] ai_class;
		logic       target_present;
		logic [7:0] still_energy;
		logic [9:0] still_distance;
	} req_t;

	typedef struct packed {
		event_t      event_res;
		logic        is_asleep;
		logic        is_breathing;
		logic [15:0] movement_total;
		logic        high_sensitivity;
		class_t      current_class;
	} res_t;

	typedef struct packed {
		logic [7:0]  breath_score;
		logic [7:0]  stable_run;
		logic        breathing;
		logic        asleep;
		logic [15:0] movement_count;
		class_t      class_now;
		class_t      class_before;
		logic        sensitivity;
	} state_t;

	typedef struct packed {
		logic [7:0] energy_min;
		logic [9:0] max_dist;
	} cfg_t;

endpackage

// ----- rtl/rsd_if.sv -----
// Channel interfaces of the radar sleep detector: request, result and
// configuration write channels. No package dependencies.
interface rsd_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic       ai_confident;
	logic [1:0] ai_class;
	logic       target_present;
	logic [7:0] still_energy;
	logic [9:0] still_distance;

	modport source (output valid, req_type, ai_confident, ai_class, target_present,
		still_energy, still_distance, input ready);
	modport sink (input valid, req_type, ai_confident, ai_class, target_present,
		still_energy, still_distance, output ready);
endinterface

interface rsd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  event_res;
	logic        is_asleep;
	logic        is_breathing;
	logic [15:0] movement_total;
	logic        high_sensitivity;
	logic [1:0]  current_class;

	modport source (output valid, event_res, is_asleep, is_breathing, movement_total,
		high_sensitivity, current_class, input ready);
	modport sink (input valid, event_res, is_asleep, is_breathing, movement_total,
		high_sensitivity, current_class, output ready);
endinterface

interface rsd_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [9:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// ----- rtl/rsd_cfg.sv -----
// Configuration registers of the radar sleep detector (energy floor and
// distance ceiling of the breathing window). Depends on rsd_pkg, rsd_if.
module rsd_cfg (
	input  logic          clk,
	input  logic          arst_n,
	rsd_cfg_if.sink       cfg,
	output rsd_pkg::cfg_t regs
);
	import rsd_pkg::*;

	cfg_t regs_q;

	// Writes are always taken
	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.energy_min <= ENERGY_MIN_RST;
			regs_q.max_dist   <= MAX_DIST_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				CFG_ENERGY_MIN: regs_q.energy_min <= cfg.wdata[7:0];
				CFG_MAX_DIST:   regs_q.max_dist   <= cfg.wdata;
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/rsd_step.sv -----
// Next-state and event logic of the radar sleep detector for one request.
// Purely combinational. Depends on rsd_pkg.
module rsd_step (
	input  rsd_pkg::state_t cur,
	input  rsd_pkg::req_t   rq,
	input  rsd_pkg::cfg_t   cfg,
	output rsd_pkg::state_t nxt,
	output rsd_pkg::event_t ev
);
	import rsd_pkg::*;

	// Breathing seen: score and run climb, flag set once the run is long enough
	function automatic state_t score_up(state_t s);
		state_t r;
		r = s;
		if (r.breath_score != SCORE_MAX) r.breath_score = r.breath_score + 8'd1;
		if (r.stable_run != SCORE_MAX) r.stable_run = r.stable_run + 8'd1;
		if (r.stable_run >= RUN_LEVEL) r.breathing = 1'b1;
		return r;
	endfunction

	// No breathing: score decays, run and flag drop
	function automatic state_t score_down(state_t s);
		state_t r;
		r = s;
		if (r.breath_score != 8'd0) r.breath_score = r.breath_score - 8'd1;
		r.stable_run = 8'd0;
		r.breathing  = 1'b0;
		return r;
	endfunction

	state_t ns;
	event_t ev_c;
	class_t cls;
	logic   in_window;

	assign cls = class_t'(rq.ai_class);
	assign in_window = (rq.still_energy > cfg.energy_min) && (rq.still_distance != 10'd0)
		&& (rq.still_distance < cfg.max_dist);

	always_comb begin
		ns   = cur;
		ev_c = EV_NONE;
		unique case (rq.req_type)
			REQ_READING: begin
				if (rq.ai_confident) begin
					// Classifier verdict drives the update
					ns.class_now = cls;
					case (cls)
						CLS_ABSENT: begin
							ns = score_down(ns);
							if (ns.breath_score == 8'd0 && ns.asleep) ev_c = EV_MOVE;
						end
						CLS_STABLE: ns = score_up(ns);
						CLS_RESTLESS: begin
							ns = score_down(ns);
							if (ns.asleep && cur.class_before == CLS_STABLE) ev_c = EV_MOVE;
						end
						default: ; // other: score, run and flag kept
					endcase
					if (cls != CLS_ABSENT && ev_c == EV_NONE
						&& ns.breath_score >= SLEEP_LEVEL && !ns.asleep) begin
						ns.asleep = 1'b1;
						ev_c = EV_START;
					end
					ns.class_before = cls;
				end else begin
					// Energy and distance window
					ns.class_now = CLS_ABSENT;
					if (!rq.target_present) begin
						ns = score_down(ns);
						if (ns.breath_score == 8'd0 && ns.asleep) ev_c = EV_MOVE;
					end else begin
						if (in_window) ns = score_up(ns);
						else ns = score_down(ns);
						if (ns.breath_score >= SLEEP_LEVEL && !ns.asleep) begin
							ns.asleep = 1'b1;
							ev_c = EV_START;
						end
					end
				end
				if (ev_c == EV_MOVE && ns.movement_count != MOVE_MAX)
					ns.movement_count = ns.movement_count + 16'd1;
			end
			REQ_START: begin
				if (!cur.asleep) begin
					ns.asleep = 1'b1;
					ns.breath_score = SLEEP_LEVEL;
					ev_c = EV_START;
				end
			end
			REQ_WAKE: begin
				if (cur.asleep) begin
					ns.asleep = 1'b0;
					ns.breath_score = 8'd0;
					ev_c = EV_END;
				end
			end
			REQ_ENTER: begin
				ns.sensitivity    = 1'b1;
				ns.breathing      = 1'b0;
				ns.stable_run     = 8'd0;
				ns.breath_score   = 8'd0;
				ns.asleep         = 1'b0;
				ns.movement_count = 16'd0;
				ns.class_now      = CLS_ABSENT;
				ns.class_before   = CLS_ABSENT;
			end
			REQ_EXIT: begin
				ns.sensitivity = 1'b0;
				if (cur.asleep) begin
					ns.asleep = 1'b0;
					ev_c = EV_END;
				end
			end
			default: ; // unknown request: no change
		endcase
	end

	assign nxt = ns;
	assign ev  = ev_c;

endmodule

// ----- rtl/radar_sleep_detector.sv -----
// Top level of the radar sleep detector: request register, session state,
// result register. Depends on rsd_pkg, rsd_if, rsd_cfg, rsd_step.
//
// Usage:
//   req: one request per handshake (reading, manual start, manual wake,
//        enter, exit) with the radar and classifier fields.
//   res: exactly one result per request, in order: event code, asleep and
//        breathing flags, movement count, sensitivity and current class.
//   cfg: register writes (0 energy floor, 1 distance ceiling), always ready;
//        write only while no request is in flight.
// Flow: an accepted request passes the request register, then the result register.
// Throughput: one request per cycle while results are taken; the state update is a
// single pass of compare and saturating-counter logic between the request register
// and the state/result registers.
// Reset: clears session state, empties both stages, loads register defaults
// (energy floor 20, distance ceiling 200).
// Stall: while res.ready is low the result is held; one further request
// waits in the request register, after which req.ready drops.
module radar_sleep_detector (
	input  logic      clk,
	input  logic      arst_n,
	rsd_cfg_if.sink   cfg,
	rsd_req_if.sink   req,
	rsd_res_if.source res
);
	import rsd_pkg::*;

	cfg_t   cfg_regs;
	req_t   req_s1;
	logic   valid_s1;
	res_t   res_s2;
	logic   valid_s2;
	state_t state_q;
	state_t state_nxt;
	event_t ev;
	logic   out_free;
	logic   advance;

	rsd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_regs)
	);

	rsd_step u_step (
		.cur (state_q),
		.rq  (req_s1),
		.cfg (cfg_regs),
		.nxt (state_nxt),
		.ev  (ev)
	);

	// Flow control
	assign out_free  = !valid_s2 || res.ready;
	assign advance   = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.req_type       <= req.req_type;
			req_s1.ai_confident   <= req.ai_confident;
			req_s1.ai_class       <= req.ai_class;
			req_s1.target_present <= req.target_present;
			req_s1.still_energy   <= req.still_energy;
			req_s1.still_distance <= req.still_distance;
		end
	end

	// Session state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2                <= 1'b0;
			state_q.breath_score    <= 8'd0;
			state_q.stable_run      <= 8'd0;
			state_q.breathing       <= 1'b0;
			state_q.asleep          <= 1'b0;
			state_q.movement_count  <= 16'd0;
			state_q.class_now       <= CLS_ABSENT;
			state_q.class_before    <= CLS_ABSENT;
			state_q.sensitivity     <= 1'b0;
		end else begin
			if (out_free) valid_s2 <= valid_s1;
			if (advance) state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.event_res        <= ev;
			res_s2.is_asleep        <= state_nxt.asleep;
			res_s2.is_breathing     <= state_nxt.breathing;
			res_s2.movement_total   <= state_nxt.movement_count;
			res_s2.high_sensitivity <= state_nxt.sensitivity;
			res_s2.current_class    <= state_nxt.class_now;
		end
	end

	assign res.valid            = valid_s2;
	assign res.event_res        = res_s2.event_res;
	assign res.is_asleep        = res_s2.is_asleep;
	assign res.is_breathing     = res_s2.is_breathing;
	assign res.movement_total   = res_s2.movement_total;
	assign res.high_sensitivity = res_s2.high_sensitivity;
	assign res.current_class    = res_s2.current_class;

endmodule
